// File: src/tmmp_pkg.sv
// Shared types, constants and helpers for the tribonacci matrix-power block.
// No dependencies; used by tmmp_mac, the top level and the checker.
package tmmp_pkg;

	localparam int INDEX_BITS_DEF = 31;
	localparam int ELEM_BITS      = 30;
	localparam int MAT_DIM        = 3;
	localparam int MAT_SIZE       = MAT_DIM * MAT_DIM;
	localparam int SLOT_BITS      = $clog2(MAT_SIZE);
	localparam int DIM_BITS       = $clog2(MAT_DIM);

	typedef logic [ELEM_BITS-1:0] elem_t;
	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [DIM_BITS-1:0]  dim_t;

	localparam elem_t MODULUS = 30'd1000000007;
	localparam logic [31:0] MOD_W  = 32'(MODULUS);
	localparam logic [31:0] MOD_W2 = MOD_W << 1;

	// Barrett factor floor(2^60 / p), fits in 31 bits
	localparam logic [63:0] MU_WIDE    = (64'd1 << 60) / 64'd1000000007;
	localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

	localparam dim_t DIM_LAST = dim_t'(MAT_DIM - 1);

	// row-major 3x3 constants
	localparam elem_t IDENT_INIT [MAT_SIZE] = '{
		30'd1, 30'd0, 30'd0,
		30'd0, 30'd1, 30'd0,
		30'd0, 30'd0, 30'd1
	};
	localparam elem_t TRANS_INIT [MAT_SIZE] = '{
		30'd0, 30'd1, 30'd0,
		30'd0, 30'd0, 30'd1,
		30'd1, 30'd1, 30'd1
	};
	localparam elem_t SEED_VEC [MAT_DIM] = '{30'd1, 30'd1, 30'd2};

	// tag that rides along with each product through the multiplier
	typedef struct packed {
		logic  first;
		logic  last;
		slot_t slot;
	} tag_t;

	function automatic slot_t slot_of(dim_t row, dim_t col);
		return slot_t'(row) * slot_t'(MAT_DIM) + slot_t'(col);
	endfunction

endpackage

// File: src/tribonacci_mod_matrix_power.sv
// Top level: tribonacci term f(n) mod 1000000007 by 3x3 matrix square-and-multiply.
// Depends on tmmp_pkg and tmmp_mac (shared modular multiply-accumulate).
//
//  channel | signals                        | dir | beat
//  --------+--------------------------------+-----+---------------------------
//  request | req_valid, req_ready, term_index | in  | one index n per beat
//  result  | rsp_valid, rsp_ready, term_value | out | f(n) mod p per beat
//
// Each 3x3 product is one step to pick the operation, 27 entry products through the
// one modular multiplier at one per cycle, and a wait for its pipeline to drain.
// A result for n of one needs only the dot product of row 0 with the seed, and n of
// zero goes straight to the result, which is then zero.
// req_ready is high only while idle; a new request is taken while a result waits.
// Reset returns to idle with no result pending.
module tribonacci_mod_matrix_power #(
	parameter int INDEX_BITS = tmmp_pkg::INDEX_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [INDEX_BITS-1:0]          term_index,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [tmmp_pkg::ELEM_BITS-1:0] term_value
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_ISSUE  = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		OP_ACC,  // acc  = acc  * base
		OP_SQR,  // base = base * base
		OP_DOT   // result = acc row 0 . seed
	} op_t;

	state_t state_q;
	op_t    op_q;
	logic [INDEX_BITS-1:0] exp_q;
	logic   did_acc_q;
	tmmp_pkg::dim_t row_q, col_q, inner_q;
	logic   rsp_valid_q;
	tmmp_pkg::elem_t term_value_q;
	tmmp_pkg::elem_t final_q;
	tmmp_pkg::elem_t acc_q  [tmmp_pkg::MAT_SIZE];
	tmmp_pkg::elem_t base_q [tmmp_pkg::MAT_SIZE];
	tmmp_pkg::elem_t opa_q  [tmmp_pkg::MAT_SIZE];
	tmmp_pkg::elem_t res_q  [tmmp_pkg::MAT_SIZE];

	logic            issue_valid;
	tmmp_pkg::elem_t op_a, op_b;
	tmmp_pkg::tag_t  issue_tag;
	logic            last_issue;
	logic            mac_busy;
	logic            mac_res_valid;
	tmmp_pkg::slot_t mac_res_slot;
	tmmp_pkg::elem_t mac_res_value;
	logic            exp_zero, exp_upper_zero, opa_from_acc, out_load;

	assign exp_zero       = (exp_q == '0);
	assign exp_upper_zero = (exp_q[INDEX_BITS-1:1] == '0);
	assign opa_from_acc   = exp_zero || (exp_q[0] && !did_acc_q);
	assign out_load       = (state_q == ST_OUT) && (!rsp_valid_q || rsp_ready);

	assign issue_valid = (state_q == ST_ISSUE);
	assign op_a = opa_q[tmmp_pkg::slot_of(row_q, inner_q)];
	assign op_b = (op_q == OP_DOT) ? tmmp_pkg::SEED_VEC[inner_q] :
		base_q[tmmp_pkg::slot_of(inner_q, col_q)];
	assign issue_tag.first = (inner_q == '0);
	assign issue_tag.last  = (inner_q == tmmp_pkg::DIM_LAST);
	assign issue_tag.slot  = tmmp_pkg::slot_of(row_q, col_q);
	assign last_issue = (inner_q == tmmp_pkg::DIM_LAST) && ((op_q == OP_DOT) ||
		((row_q == tmmp_pkg::DIM_LAST) && (col_q == tmmp_pkg::DIM_LAST)));

	tmmp_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue_valid (issue_valid),
		.op_a        (op_a),
		.op_b        (op_b),
		.issue_tag   (issue_tag),
		.busy        (mac_busy),
		.res_valid   (mac_res_valid),
		.res_slot    (mac_res_slot),
		.res_value   (mac_res_value)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_DOT;
			exp_q       <= '0;
			did_acc_q   <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			inner_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && !out_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						exp_q     <= term_index - INDEX_BITS'(1);
						did_acc_q <= 1'b0;
						state_q   <= (term_index == '0) ? ST_OUT : ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					row_q   <= '0;
					col_q   <= '0;
					inner_q <= '0;
					if (exp_zero) begin
						op_q    <= OP_DOT;
						state_q <= ST_ISSUE;
					end else if (exp_q[0] && !did_acc_q) begin
						op_q    <= OP_ACC;
						state_q <= ST_ISSUE;
					end else if (!exp_upper_zero) begin
						op_q    <= OP_SQR;
						state_q <= ST_ISSUE;
					end else begin
						// last squaring would go unused: just retire the bit
						exp_q     <= exp_q >> 1;
						did_acc_q <= 1'b0;
					end
				end
				ST_ISSUE: begin
					if (inner_q == tmmp_pkg::DIM_LAST) begin
						inner_q <= '0;
						if (col_q == tmmp_pkg::DIM_LAST) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end else begin
						inner_q <= inner_q + 1'b1;
					end
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mac_busy) begin
						case (op_q)
							OP_ACC: begin
								did_acc_q <= 1'b1;
								state_q   <= ST_DECIDE;
							end
							OP_SQR: begin
								exp_q     <= exp_q >> 1;
								did_acc_q <= 1'b0;
								state_q   <= ST_DECIDE;
							end
							OP_DOT: begin
								state_q <= ST_OUT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_OUT: begin
					if (out_load) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// matrix and result storage
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_valid) begin
			for (int i = 0; i < tmmp_pkg::MAT_SIZE; i++) begin
				acc_q[i]  <= tmmp_pkg::IDENT_INIT[i];
				base_q[i] <= tmmp_pkg::TRANS_INIT[i];
			end
			final_q <= '0;
		end
		if (state_q == ST_DECIDE) begin
			for (int i = 0; i < tmmp_pkg::MAT_SIZE; i++) begin
				opa_q[i] <= opa_from_acc ? acc_q[i] : base_q[i];
			end
		end
		if (mac_res_valid) begin
			if (op_q == OP_DOT) begin
				final_q <= mac_res_value;
			end else begin
				res_q[mac_res_slot] <= mac_res_value;
			end
		end
		if ((state_q == ST_DRAIN) && !mac_busy) begin
			for (int i = 0; i < tmmp_pkg::MAT_SIZE; i++) begin
				if (op_q == OP_ACC) begin
					acc_q[i] <= res_q[i];
				end else if (op_q == OP_SQR) begin
					base_q[i] <= res_q[i];
				end
			end
		end
		if (out_load) begin
			term_value_q <= final_q;
		end
	end

	assign req_ready  = (state_q == ST_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign term_value = term_value_q;

endmodule

// File: src/tmmp_mac.sv
// Pipelined modular multiply-accumulate: one a*b mod p per cycle, Barrett reduction,
// running sum of a dot product per tag. Depends on tmmp_pkg.
module tmmp_mac (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             issue_valid,
	input  tmmp_pkg::elem_t  op_a,
	input  tmmp_pkg::elem_t  op_b,
	input  tmmp_pkg::tag_t   issue_tag,
	output logic             busy,
	output logic             res_valid,
	output tmmp_pkg::slot_t  res_slot,
	output tmmp_pkg::elem_t  res_value
);

	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;
	tmmp_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [59:0] prod_s1;
	logic [30:0] q3_s2;
	logic [31:0] xlo_s2;
	logic [31:0] r_s3;
	tmmp_pkg::elem_t m_s4;
	tmmp_pkg::elem_t sum_q;
	tmmp_pkg::slot_t res_slot_q;
	tmmp_pkg::elem_t res_value_q;

	logic [61:0] q2_full;
	logic [60:0] qp_full;
	logic [31:0] r_red;
	logic [30:0] sum_add, sum_red;
	tmmp_pkg::elem_t sum_nxt;

	// q3 = floor((x >> 29) * mu / 2^31); x - q3*p lands in [0, 3p)
	assign q2_full = 62'(prod_s1[59:29]) * 62'(tmmp_pkg::BARRETT_MU);
	assign qp_full = 61'(q3_s2) * 61'(tmmp_pkg::MODULUS);

	always_comb begin
		if (r_s3 >= tmmp_pkg::MOD_W2) begin
			r_red = r_s3 - tmmp_pkg::MOD_W2;
		end else if (r_s3 >= tmmp_pkg::MOD_W) begin
			r_red = r_s3 - tmmp_pkg::MOD_W;
		end else begin
			r_red = r_s3;
		end
	end

	assign sum_add = {1'b0, sum_q} + {1'b0, m_s4};
	assign sum_red = (sum_add >= 31'(tmmp_pkg::MODULUS)) ?
		sum_add - 31'(tmmp_pkg::MODULUS) : sum_add;
	assign sum_nxt = tag_s4.first ? m_s4 : sum_red[tmmp_pkg::ELEM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1        <= issue_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			res_valid_q <= v_s4 && tag_s4.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 60'(op_a) * 60'(op_b);
		tag_s1  <= issue_tag;
		q3_s2   <= q2_full[61:31];
		xlo_s2  <= prod_s1[31:0];
		tag_s2  <= tag_s1;
		r_s3    <= xlo_s2 - qp_full[31:0];
		tag_s3  <= tag_s2;
		m_s4    <= r_red[tmmp_pkg::ELEM_BITS-1:0];
		tag_s4  <= tag_s3;
		if (v_s4) begin
			sum_q       <= sum_nxt;
			res_value_q <= sum_nxt;
			res_slot_q  <= tag_s4.slot;
		end
	end

	assign busy      = v_s1 | v_s2 | v_s3 | v_s4 | res_valid_q;
	assign res_valid = res_valid_q;
	assign res_slot  = res_slot_q;
	assign res_value = res_value_q;

endmodule

// File: src/tmmp_checker.sv
// Port-level checks for tribonacci_mod_matrix_power, attached by bind.
// Depends on tmmp_pkg.
module tmmp_checker #(
	parameter int INDEX_BITS = tmmp_pkg::INDEX_BITS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic [INDEX_BITS-1:0]          term_index,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [tmmp_pkg::ELEM_BITS-1:0] term_value
);

	// a stalled result beat stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(term_value))
		else $error("term_value changed while stalled");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> term_value < tmmp_pkg::MODULUS)
		else $error("term_value not reduced");

	// one index at a time: busy right after a request beat
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while still working");

	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared from idle");

endmodule

bind tribonacci_mod_matrix_power tmmp_checker #(.INDEX_BITS(INDEX_BITS)) u_tmmp_checker (.*);
